// ===== rtl/core/crsf_pkg.sv =====
// ----------------------------------------------------------------------------
// crsf_pkg
// Shared types, constants and the CRC-8 DVB-S2 byte update for the CRSF
// frame receiver.
// ----------------------------------------------------------------------------
package crsf_pkg;

    // sync bytes that open a frame
    localparam logic [7:0] SYNC_A = 8'hC8;
    localparam logic [7:0] SYNC_B = 8'hEA;
    localparam logic [7:0] SYNC_C = 8'hEE;

    // crc-8 dvb-s2 polynomial and top bit
    localparam logic [7:0] CRC_POLY = 8'hD5;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    // frame length limits
    localparam int         LEN_W       = 7;
    localparam logic [6:0] LEN_CEILING = 7'd64;
    localparam logic [7:0] LEN_MIN     = 8'd2;

    // configuration register reset values
    localparam logic [6:0] MAX_LEN_RESET  = 7'd64;
    localparam logic [7:0] TEL_TYPE_RESET = 8'h08;

    // configuration register indexes
    localparam int         CFG_ADDR_W   = 1;
    localparam logic [0:0] CFG_MAX_LEN  = 1'b0;
    localparam logic [0:0] CFG_TEL_TYPE = 1'b1;

    // configuration write data width (widest register)
    localparam int CFG_DATA_W = 8;

    // result stream width: 18 field bits padded to whole bytes
    localparam int RES_BITS = 18;
    localparam int RES_W    = 24;

    // parser phases, one-hot
    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_LEN  = 3'b010,
        PH_DATA = 3'b100
    } phase_t;

    // one completed frame, from the parser to the result register
    typedef struct packed {
        logic             valid;
        logic [7:0]       frame_type;
        logic [LEN_W-1:0] frame_length;
        logic             crc_ok;
        logic             telemetry_seen;
        logic             link_active;
    } result_t;

    // crc-8 dvb-s2 update over one byte, msb first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                               input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if ((v & CRC_TOP) != 8'h00)
            begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/crsf_parser.sv =====
// ----------------------------------------------------------------------------
// crsf_parser
// Frame parse state and running CRC. Looks at one byte per enabled cycle and
// reports a completed frame combinationally on the byte that ends it.
// ----------------------------------------------------------------------------
module crsf_parser (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic [7:0]              rx_byte,
    input  logic [crsf_pkg::LEN_W-1:0] max_frame_length,
    input  logic [7:0]              telemetry_frame_type,
    output crsf_pkg::result_t       res
);
    import crsf_pkg::*;

    phase_t           phase_reg,    phase_next;
    logic [LEN_W-1:0] expected_reg, expected_next;
    logic [LEN_W-1:0] received_reg, received_next;
    logic [7:0]       crc_reg,      crc_next;
    logic [7:0]       type_reg,     type_next;
    logic             link_reg,     link_next;

    logic [LEN_W-1:0] max_len;
    logic             len_ok;
    logic             is_sync;
    logic             crc_ok;
    logic             tel;

    // effective maximum length, clamped to the ceiling
    assign max_len = (max_frame_length > LEN_CEILING) ? LEN_CEILING : max_frame_length;
    assign len_ok  = (rx_byte >= LEN_MIN) && (rx_byte <= {1'b0, max_len});
    assign is_sync = (rx_byte == SYNC_A) || (rx_byte == SYNC_B) || (rx_byte == SYNC_C);
    assign crc_ok  = (crc_reg == rx_byte);
    assign tel     = crc_ok && (type_reg == telemetry_frame_type);

    // next state and frame result
    always_comb
    begin
        phase_next    = phase_reg;
        expected_next = expected_reg;
        received_next = received_reg;
        crc_next      = crc_reg;
        type_next     = type_reg;
        link_next     = link_reg;
        res           = '0;

        case (phase_reg)
            PH_LEN:
            begin
                if (len_ok)
                begin
                    expected_next = rx_byte[LEN_W-1:0];
                    received_next = '0;
                    crc_next      = 8'h00;
                    phase_next    = PH_DATA;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_DATA:
            begin
                received_next = received_reg + 1'b1;
                if (received_next == LEN_W'(1))
                begin
                    type_next = rx_byte;
                end
                if (received_next < expected_reg)
                begin
                    crc_next = crc8_update(crc_reg, rx_byte);
                end
                else
                begin
                    // final byte: compare against the running crc
                    link_next          = link_reg | tel;
                    res.valid          = 1'b1;
                    res.frame_type     = type_reg;
                    res.frame_length   = expected_reg;
                    res.crc_ok         = crc_ok;
                    res.telemetry_seen = tel;
                    res.link_active    = link_reg | tel;
                    phase_next         = PH_HUNT;
                end
            end
            default:
            begin
                // hunting, and any phase code that means nothing
                phase_next = is_sync ? PH_LEN : PH_HUNT;
            end
        endcase

        if (!en)
        begin
            res.valid = 1'b0;
        end
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            expected_reg <= '0;
            received_reg <= '0;
            crc_reg      <= 8'h00;
            type_reg     <= 8'h00;
            link_reg     <= 1'b0;
        end
        else if (en)
        begin
            phase_reg    <= phase_next;
            expected_reg <= expected_next;
            received_reg <= received_next;
            crc_reg      <= crc_next;
            type_reg     <= type_next;
            link_reg     <= link_next;
        end
    end

endmodule

// ===== rtl/core/crsf_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// crsf_frame_receiver_core
// CRSF frame receiver: hunts for sync, checks the length byte, runs CRC-8
// DVB-S2 over type and payload and reports each completed frame.
// ----------------------------------------------------------------------------
//
//  channel   direction  width  contents
//  s_axis    in         8      rx_byte
//  m_axis    out        24     frame_type, frame_length, crc_ok,
//                              telemetry_seen, link_active
//  cfg       in         1+8    max_frame_length (0), telemetry_frame_type (1)
//
//  One byte is taken per cycle while the input side is not held; the final
//  byte of a frame is registered in the input register, parsed, and its result
//  is captured in the result register. The parse step and the unrolled CRC byte
//  update sit between those two registers.
//  A stalled result holds the input side only once the input register is full.
//  Reset returns the parser to hunting and clears the link flag.
//
module crsf_frame_receiver_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // rx_byte [7:0]
    input  logic [7:0]                          s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // frame_type [7:0], frame_length [14:8], crc_ok [15],
    // telemetry_seen [16], link_active [17], zero [23:18]
    output logic [crsf_pkg::RES_W-1:0]          m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_we,
    input  logic [crsf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [crsf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import crsf_pkg::*;

    logic [LEN_W-1:0] max_len_reg;
    logic [7:0]       tel_type_reg;
    logic [7:0]       in_byte_reg;
    logic             in_valid_reg;
    logic [RES_W-1:0] out_data_reg;
    logic             out_valid_reg;
    logic             advance;
    result_t          res;

    // the input stage moves on when the result register can take a request
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tdata  = out_data_reg;
    assign m_tvalid = out_valid_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg  <= MAX_LEN_RESET;
            tel_type_reg <= TEL_TYPE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MAX_LEN:  max_len_reg  <= cfg_wdata[LEN_W-1:0];
                CFG_TEL_TYPE: tel_type_reg <= cfg_wdata[7:0];
                default:      ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    crsf_parser u_parser (
        .clk                  (clk),
        .rst_n                (rst_n),
        .en                   (advance),
        .rx_byte              (in_byte_reg),
        .max_frame_length     (max_len_reg),
        .telemetry_frame_type (tel_type_reg),
        .res                  (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            out_data_reg <= {(RES_W - RES_BITS)'(0), res.link_active, res.telemetry_seen,
                             res.crc_ok, res.frame_length, res.frame_type};
        end
    end

endmodule

// ===== rtl/core/crsf_checker.sv =====
// ----------------------------------------------------------------------------
// crsf_checker
// Port-level checks for the CRSF frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module crsf_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [crsf_pkg::RES_W-1:0]       m_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready
);
    import crsf_pkg::*;

    // a stalled result request holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reported length lies in the accepted range
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[14:8] >= 7'd2) && (m_tdata[14:8] <= LEN_CEILING))
        else $error("frame length out of range");

    // telemetry only on a frame whose crc matched
    a_tel_crc: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[16] |-> m_tdata[15])
        else $error("telemetry flagged without crc match");

    // a telemetry frame leaves the link active
    a_tel_link: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[16] |-> m_tdata[17])
        else $error("telemetry frame without link active");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[RES_W-1:RES_BITS] == '0)
        else $error("nonzero padding in result");

endmodule

bind crsf_frame_receiver_core crsf_checker u_crsf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// ===== tb/crsf_frame_receiver_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_frame_receiver_core_tb
// Streams received bytes into the CRSF frame receiver and checks every
// reported frame against a cycle-free parser model kept in the bench. A short
// directed sequence covers sync hunting, length rejection and CRC failures;
// random traffic of mostly well-formed frames then runs under several
// register settings with random stalls on both stream sides.
// ----------------------------------------------------------------------------
module crsf_frame_receiver_core_tb;

    import crsf_pkg::*;

    localparam int IDLE_PCT     = 22;
    localparam int DRAIN_CYCLES = 6;
    localparam int CALM_FROM    = 400;
    localparam int CALM_TO      = 900;
    localparam int RUN_LIMIT_NS = 2_000_000;

    // one reported frame as the parser model sees it
    typedef struct packed {
        logic [7:0]       ftype;
        logic [LEN_W-1:0] flen;
        logic             crc_ok;
        logic             tel_seen;
        logic             link;
    } frame_report_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic [7:0]            s_tdata   = 8'h00;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [RES_W-1:0]      m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_MAX_LEN;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // stimulus and expectation stores
    logic [7:0]    rx_bytes_pending[$];
    frame_report_t frame_reports[$];
    logic          rx_request_taken = 1'b0;
    int            cyc              = 0;
    int            errs             = 0;

    // parser model state and its copy of the registers
    logic [6:0] mdl_max_len  = MAX_LEN_RESET;
    logic [7:0] mdl_tel_type = TEL_TYPE_RESET;
    phase_t     mdl_phase    = PH_HUNT;
    logic [6:0] mdl_want     = '0;
    logic [6:0] mdl_got      = '0;
    logic [7:0] mdl_crc      = '0;
    logic [7:0] mdl_type     = '0;
    logic       mdl_link     = 1'b0;

    wire calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

    crsf_frame_receiver_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // crc-8 dvb-s2, poly 0xd5, msb first, no reflection
    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        r = acc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic is_sync(input logic [7:0] b);
        return (b == SYNC_A) || (b == SYNC_B) || (b == SYNC_C);
    endfunction

    function automatic logic [6:0] usable_max_len();
        return (mdl_max_len > LEN_CEILING) ? LEN_CEILING : mdl_max_len;
    endfunction

    // advance the parser model by one accepted byte
    task automatic parse_rx_byte(input logic [7:0] b);
        frame_report_t rep;
        logic          ok;
        case (mdl_phase)
            PH_LEN:
            begin
                if (b >= LEN_MIN && b <= {1'b0, usable_max_len()})
                begin
                    mdl_want  = b[6:0];
                    mdl_got   = '0;
                    mdl_crc   = '0;
                    mdl_phase = PH_DATA;
                end
                else
                begin
                    mdl_phase = PH_HUNT;
                end
            end
            PH_DATA:
            begin
                mdl_got = mdl_got + 7'd1;
                if (mdl_got == 7'd1)
                begin
                    mdl_type = b;
                end
                if (mdl_got < mdl_want)
                begin
                    mdl_crc = crc8_step(mdl_crc, b);
                end
                else
                begin
                    ok = (mdl_crc == b);
                    rep.ftype    = mdl_type;
                    rep.flen     = mdl_want;
                    rep.crc_ok   = ok;
                    rep.tel_seen = ok && (mdl_type == mdl_tel_type);
                    if (rep.tel_seen)
                    begin
                        mdl_link = 1'b1;
                    end
                    rep.link  = mdl_link;
                    frame_reports.push_back(rep);
                    mdl_phase = PH_HUNT;
                end
            end
            default:
            begin
                mdl_phase = is_sync(b) ? PH_LEN : PH_HUNT;
            end
        endcase
    endtask

    // compare one reported frame with the oldest expectation
    task automatic check_report(input logic [RES_W-1:0] d);
        frame_report_t want;
        if (frame_reports.size() == 0)
        begin
            $error("unexpected frame report %0h", d);
            errs++;
        end
        else
        begin
            want = frame_reports.pop_front();
            if (d[7:0] !== want.ftype)
            begin
                $error("frame_type expected %0h got %0h", want.ftype, d[7:0]);
                errs++;
            end
            if (d[14:8] !== want.flen)
            begin
                $error("frame_length expected %0d got %0d", want.flen, d[14:8]);
                errs++;
            end
            if (d[15] !== want.crc_ok)
            begin
                $error("crc_ok expected %0b got %0b", want.crc_ok, d[15]);
                errs++;
            end
            if (d[16] !== want.tel_seen)
            begin
                $error("telemetry_seen expected %0b got %0b", want.tel_seen, d[16]);
                errs++;
            end
            if (d[17] !== want.link)
            begin
                $error("link_active expected %0b got %0b", want.link, d[17]);
                errs++;
            end
            if (d[RES_W-1:RES_BITS] !== '0)
            begin
                $error("padding expected 0 got %0h", d[RES_W-1:RES_BITS]);
                errs++;
            end
        end
    endtask

    // monitor: take accepted bytes into the model, check accepted results
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        rx_request_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            parse_rx_byte(s_tdata);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            check_report(m_tdata);
        end
    end

    // driver: present the next pending byte, random gaps and result stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || rx_request_taken)
            begin
                if (rx_bytes_pending.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    s_tdata  <= rx_bytes_pending.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // register write, model copy follows
    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx == CFG_MAX_LEN)
        begin
            mdl_max_len = val[6:0];
        end
        else
        begin
            mdl_tel_type = val;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every byte is taken and every report has come back
    task automatic wait_drained();
        do
        begin
            @(posedge clk);
        end
        while (rx_bytes_pending.size() != 0 || s_tvalid || frame_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_sync();
        case ($urandom_range(0, 2))
            0:       return SYNC_A;
            1:       return SYNC_B;
            default: return SYNC_C;
        endcase
    endfunction

    // queue sync, length, type, random payload and crc; returns bytes queued
    function automatic int push_frame(input logic [7:0] sync, input int flen,
                                      input logic [7:0] ftype, input logic bad_crc);
        logic [7:0] acc;
        logic [7:0] pb;
        rx_bytes_pending.push_back(sync);
        rx_bytes_pending.push_back(flen[7:0]);
        rx_bytes_pending.push_back(ftype);
        acc = crc8_step(8'h00, ftype);
        for (int i = 0; i < flen - 2; i++)
        begin
            pb = $urandom_range(0, 255);
            rx_bytes_pending.push_back(pb);
            acc = crc8_step(acc, pb);
        end
        if (bad_crc)
        begin
            acc = acc ^ 8'($urandom_range(1, 255));
        end
        rx_bytes_pending.push_back(acc);
        return flen + 2;
    endfunction

    // random traffic: mostly good frames, some bad lengths, noise, cut frames
    task automatic random_traffic(input int budget);
        int         sent;
        int         sel;
        int         flen;
        int         eff;
        int         cut;
        logic [7:0] ftype;
        sent = 0;
        eff  = usable_max_len();
        while (sent < budget)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
            begin
                if (eff < 2)
                begin
                    flen = $urandom_range(2, 10);
                end
                else if ($urandom_range(0, 99) < 8)
                begin
                    flen = eff;
                end
                else
                begin
                    flen = $urandom_range(2, (eff < 10) ? eff : 10);
                end
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: ftype = mdl_tel_type;
                    4:          ftype = pick_sync();
                    default:    ftype = $urandom_range(0, 255);
                endcase
                sent += push_frame(pick_sync(), flen, ftype, $urandom_range(0, 99) < 15);
            end
            else if (sel < 80)
            begin
                rx_bytes_pending.push_back(pick_sync());
                case ($urandom_range(0, 4))
                    0:       rx_bytes_pending.push_back(8'd0);
                    1:       rx_bytes_pending.push_back(8'd1);
                    2:       rx_bytes_pending.push_back(8'(eff + 1));
                    3:       rx_bytes_pending.push_back(8'hFF);
                    default: rx_bytes_pending.push_back(8'($urandom_range(eff + 1, 255)));
                endcase
                sent += 2;
            end
            else if (sel < 90)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    rx_bytes_pending.push_back(8'($urandom_range(0, 255)));
                    sent++;
                end
            end
            else
            begin
                // frame cut short, the next bytes complete it as data
                flen = (eff < 2) ? 2 : $urandom_range(2, (eff < 10) ? eff : 10);
                cut  = $urandom_range(0, flen - 1);
                rx_bytes_pending.push_back(pick_sync());
                rx_bytes_pending.push_back(8'(flen));
                repeat (cut) rx_bytes_pending.push_back(8'($urandom_range(0, 255)));
                sent += cut + 2;
            end
        end
    endtask

    // stimulus sequence
    initial
    begin
        int dummy;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset registers, max length 64 and telemetry type 8
        dummy = push_frame(SYNC_A, 2, 8'h00, 1'b0);
        dummy = push_frame(SYNC_B, 2, 8'h08, 1'b1);
        dummy = push_frame(SYNC_C, 3, 8'h08, 1'b0);
        rx_bytes_pending.push_back(8'h00);
        rx_bytes_pending.push_back(SYNC_A);
        // sync value as bad length is not taken as a new sync
        rx_bytes_pending.push_back(SYNC_C);
        rx_bytes_pending.push_back(8'hFF);
        rx_bytes_pending.push_back(SYNC_B);
        rx_bytes_pending.push_back(8'd65);
        rx_bytes_pending.push_back(SYNC_C);
        rx_bytes_pending.push_back(8'd1);
        // sync value inside a frame is plain data
        dummy = push_frame(SYNC_A, 2, SYNC_B, 1'b0);
        wait_drained();

        // random phases over several register settings
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:
                begin
                    cfg_write(CFG_MAX_LEN, 8'd2);
                    cfg_write(CFG_TEL_TYPE, 8'h00);
                end
                1:
                begin
                    cfg_write(CFG_MAX_LEN, 8'd127);
                    cfg_write(CFG_TEL_TYPE, 8'hFF);
                end
                2:
                begin
                    cfg_write(CFG_MAX_LEN, 8'd0);
                    cfg_write(CFG_TEL_TYPE, TEL_TYPE_RESET);
                end
                3:
                begin
                    cfg_write(CFG_MAX_LEN, 8'd1);
                    cfg_write(CFG_TEL_TYPE, 8'($urandom_range(0, 255)));
                end
                4:
                begin
                    cfg_write(CFG_MAX_LEN, 8'd64);
                    cfg_write(CFG_TEL_TYPE, 8'($urandom_range(0, 255)));
                end
                default:
                begin
                    cfg_write(CFG_MAX_LEN, 8'($urandom_range(2, 127)));
                    cfg_write(CFG_TEL_TYPE, 8'($urandom_range(0, 255)));
                end
            endcase
            random_traffic((p == 2 || p == 3) ? 60 : 150);
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (errs == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
